>>> sv/chunked_message_deframer_assert.svh
// Assertion macros shared by the deframer's checker.
`ifndef CHUNKED_MESSAGE_DEFRAMER_ASSERT_SVH
`define CHUNKED_MESSAGE_DEFRAMER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CMD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CMD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/cmd_pkg.sv
// ----------------------------------------------------------------------------
// cmd_pkg
// Types and constants of the chunked message deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package cmd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned STAT_W = 2;

  localparam logic [STAT_W-1:0] ST_PAYLOAD   = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY_END = 2'd1;
  localparam logic [STAT_W-1:0] ST_REJECT    = 2'd2;

  localparam logic REG_CHECK_WORD = 1'b0;
  localparam logic REG_MAX_CHUNK  = 1'b1;

  localparam logic [WORD_W-1:0] CHECK_WORD_RST = 16'h00DF;
  localparam logic [WORD_W-1:0] MAX_CHUNK_RST  = 16'hFFFF;

  // header byte positions
  localparam logic [CNT_W-1:0] HB_CHK_LO  = 3'd0;
  localparam logic [CNT_W-1:0] HB_CHK_HI  = 3'd1;
  localparam logic [CNT_W-1:0] HB_RESERVE = 3'd2;
  localparam logic [CNT_W-1:0] HB_TYPE    = 3'd3;
  localparam logic [CNT_W-1:0] HB_TOTAL   = 3'd4;
  localparam logic [CNT_W-1:0] HB_CUR     = 3'd5;
  localparam logic [CNT_W-1:0] HB_SIZE_LO = 3'd6;
  localparam logic [CNT_W-1:0] HB_SIZE_HI = 3'd7;

  typedef struct packed {
    logic [WORD_W-1:0] chk;
    logic [BYTE_W-1:0] msg_type;
    logic [BYTE_W-1:0] total;
    logic [BYTE_W-1:0] cur;
    logic [BYTE_W-1:0] size_lo;
  } hdr_fields_t;

  typedef struct packed {
    logic              reject;
    logic              is_final;
    logic              empty;
    logic [WORD_W-1:0] size;
  } hdr_verdict_t;

endpackage

`default_nettype wire

>>> sv/cmd_hdr_chk.sv
// ----------------------------------------------------------------------------
// cmd_hdr_chk
// Validates a completed chunk header against the configured limits.
// ----------------------------------------------------------------------------
`default_nettype none

module cmd_hdr_chk (
  input  var cmd_pkg::hdr_fields_t              hdr,
  input  wire logic [cmd_pkg::BYTE_W-1:0]       size_hi,
  input  wire logic [cmd_pkg::WORD_W-1:0]       check_word,
  input  wire logic [cmd_pkg::WORD_W-1:0]       max_chunk_bytes,
  output cmd_pkg::hdr_verdict_t                 verdict
);

  logic [cmd_pkg::WORD_W-1:0] size;

  assign size = {size_hi, hdr.size_lo};

  always_comb begin
    verdict.size     = size;
    verdict.is_final = (hdr.cur == hdr.total);
    verdict.empty    = (size == '0);
    verdict.reject   = (hdr.chk != check_word) || (size > max_chunk_bytes) ||
                       (hdr.cur > hdr.total);
  end

endmodule

`default_nettype wire

>>> sv/chunked_message_deframer.sv
// Latency: a byte accepted at one edge shows its result, if it yields one, at the output from the next cycle.
// Throughput: one byte per cycle; the output register takes a new result whenever it
//   is empty or being drained, so only a stalled output holds off the input.
// Reset (rst_n low, synchronous): header hunting restarts, no result pending,
//   check_word returns to 0x00DF and max_chunk_bytes to 0xFFFF.
// ----------------------------------------------------------------------------
// chunked_message_deframer
// Deframes a byte stream into chunk headers and payload bytes with message type.
// ----------------------------------------------------------------------------
`default_nettype none

module chunked_message_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [15:0] out_tdata,  // [7:0] payload_byte, [15:8] message_type
  output      logic        out_tlast,  // end_of_message
  output      logic [1:0]  out_tuser   // [1:0] status
);

  logic [cmd_pkg::WORD_W-1:0] check_word_r;
  logic [cmd_pkg::WORD_W-1:0] max_chunk_r;

  logic                       in_payload_r, in_payload_nxt;
  logic [cmd_pkg::CNT_W-1:0]  hdr_cnt_r, hdr_cnt_nxt;
  cmd_pkg::hdr_fields_t       hdr_r, hdr_nxt;
  logic [cmd_pkg::WORD_W-1:0] bytes_left_r, bytes_left_nxt;
  logic                       final_r, final_nxt;
  logic [cmd_pkg::BYTE_W-1:0] type_r, type_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [cmd_pkg::BYTE_W-1:0] out_data_r, out_data_nxt;
  logic [cmd_pkg::BYTE_W-1:0] out_type_r, out_type_nxt;
  logic                       out_last_r, out_last_nxt;
  logic [cmd_pkg::STAT_W-1:0] out_stat_r, out_stat_nxt;

  logic                       accept;
  logic                       emit;
  cmd_pkg::hdr_verdict_t      verdict;

  cmd_hdr_chk u_hdr_chk (
    .hdr             (hdr_r),
    .size_hi         (in_tdata),
    .check_word      (check_word_r),
    .max_chunk_bytes (max_chunk_r),
    .verdict         (verdict)
  );

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_word_r <= cmd_pkg::CHECK_WORD_RST;
      max_chunk_r  <= cmd_pkg::MAX_CHUNK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cmd_pkg::REG_CHECK_WORD: check_word_r <= cfg_data;
        cmd_pkg::REG_MAX_CHUNK:  max_chunk_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_payload_nxt = in_payload_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    hdr_nxt        = hdr_r;
    bytes_left_nxt = bytes_left_r;
    final_nxt      = final_r;
    type_nxt       = type_r;
    emit           = 1'b0;
    out_data_nxt   = out_data_r;
    out_type_nxt   = out_type_r;
    out_last_nxt   = out_last_r;
    out_stat_nxt   = out_stat_r;

    if (accept) begin
      if (in_payload_r) begin
        emit           = 1'b1;
        out_data_nxt   = in_tdata;
        out_type_nxt   = type_r;
        out_stat_nxt   = cmd_pkg::ST_PAYLOAD;
        bytes_left_nxt = bytes_left_r - 16'd1;
        out_last_nxt   = 1'b0;
        if (bytes_left_r == 16'd1) begin
          in_payload_nxt = 1'b0;
          out_last_nxt   = final_r;
        end
      end else begin
        hdr_cnt_nxt = hdr_cnt_r + 3'd1;
        case (hdr_cnt_r)
          cmd_pkg::HB_CHK_LO:  hdr_nxt.chk[7:0]  = in_tdata;
          cmd_pkg::HB_CHK_HI:  hdr_nxt.chk[15:8] = in_tdata;
          cmd_pkg::HB_RESERVE: ;
          cmd_pkg::HB_TYPE:    hdr_nxt.msg_type  = in_tdata;
          cmd_pkg::HB_TOTAL:   hdr_nxt.total     = in_tdata;
          cmd_pkg::HB_CUR:     hdr_nxt.cur       = in_tdata;
          cmd_pkg::HB_SIZE_LO: hdr_nxt.size_lo   = in_tdata;
          cmd_pkg::HB_SIZE_HI: begin
            out_data_nxt = '0;
            out_type_nxt = hdr_r.msg_type;
            if (verdict.reject) begin
              emit         = 1'b1;
              out_last_nxt = 1'b0;
              out_stat_nxt = cmd_pkg::ST_REJECT;
            end else begin
              type_nxt  = hdr_r.msg_type;
              final_nxt = verdict.is_final;
              if (verdict.empty) begin
                emit         = verdict.is_final;
                out_last_nxt = 1'b1;
                out_stat_nxt = cmd_pkg::ST_EMPTY_END;
              end else begin
                bytes_left_nxt = verdict.size;
                in_payload_nxt = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
    end

    out_valid_nxt = (out_valid_r && !out_tready) || emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_payload_r <= 1'b0;
      hdr_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      in_payload_r <= in_payload_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r        <= hdr_nxt;
    bytes_left_r <= bytes_left_nxt;
    final_r      <= final_nxt;
    type_r       <= type_nxt;
    out_data_r   <= out_data_nxt;
    out_type_r   <= out_type_nxt;
    out_last_r   <= out_last_nxt;
    out_stat_r   <= out_stat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_type_r, out_data_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_stat_r;

endmodule

`default_nettype wire

>>> sv/cmd_checker.sv
// ----------------------------------------------------------------------------
// cmd_checker
// Port-level checks of the chunked message deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "chunked_message_deframer_assert.svh"

module cmd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic [1:0]  out_tuser
);

  `CMD_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "stalled transfer changed")
  `CMD_ASSERT_IMP(a_ready_when_empty, !out_tvalid, in_tready, "input stalled with empty output")
  `CMD_ASSERT_IMP(a_reject_shape, out_tvalid && out_tuser == cmd_pkg::ST_REJECT, !out_tlast && out_tdata[7:0] == 8'd0, "malformed reject transfer")
  `CMD_ASSERT_IMP(a_empty_end_shape, out_tvalid && out_tuser == cmd_pkg::ST_EMPTY_END, out_tlast && out_tdata[7:0] == 8'd0, "malformed empty-chunk end")
  `CMD_ASSERT_IMP(a_status_legal, out_tvalid, out_tuser <= cmd_pkg::ST_REJECT, "undefined status code")

endmodule

bind chunked_message_deframer cmd_checker u_cmd_checker (.*);

`default_nettype wire

>>> tb/sv/tb_chunked_message_deframer.sv
// ----------------------------------------------------------------------------
// tb_chunked_message_deframer
// Feeds the deframer byte streams of chunked messages, mostly well-formed
// chunk sequences plus rejected headers and noise. Runs them under several
// register settings, with random gaps on both sides and one long output
// hold-off. Each accepted byte is deframed by a local predictor and every
// result transfer is compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------

module tb_chunked_message_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  import cmd_pkg::*;

  localparam int LONG_STALL     = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_BYTES    = 260;
  localparam int DRAIN_CYCLES   = 4;

  typedef struct packed {
    logic [BYTE_W-1:0] payload;
    logic [BYTE_W-1:0] msg_type;
    logic              eom;
    logic [STAT_W-1:0] status;
  } deframed_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_index = REG_CHECK_WORD;
  logic [WORD_W-1:0] cfg_data = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [15:0]       out_tdata;
  logic              out_tlast;
  logic [1:0]        out_tuser;

  chunked_message_deframer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] rx_byte
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [7:0] payload_byte, [15:8] message_type
    .out_tlast  (out_tlast),   // end_of_message
    .out_tuser  (out_tuser)    // [1:0] status
  );

  logic [7:0]  rx_stream_q[$];
  deframed_t   deframed_q[$];
  int          mismatch_count = 0;
  bit          idle_on = 1'b1;
  int          stall_requests = 0;
  int          stall_served;
  int          stall_left;
  int          send_gap;
  int          ready_gap;
  int          quiet_cycles;

  // predictor state
  logic [WORD_W-1:0] check_word_m = CHECK_WORD_RST;
  logic [WORD_W-1:0] max_chunk_m  = MAX_CHUNK_RST;
  logic              in_chunk     = 1'b0;
  logic [CNT_W-1:0]  hdr_pos      = HB_CHK_LO;
  hdr_fields_t       hdr          = '0;
  logic [WORD_W-1:0] bytes_left   = '0;
  logic              chunk_final  = 1'b0;
  logic [BYTE_W-1:0] held_type    = '0;

  function automatic void deframe_byte(logic [7:0] b);
    deframed_t         r;
    logic [WORD_W-1:0] size;
    r = '0;
    if (in_chunk) begin
      bytes_left = bytes_left - 1'b1;
      r.payload  = b;
      r.msg_type = held_type;
      r.status   = ST_PAYLOAD;
      r.eom      = (bytes_left == 0) && chunk_final;
      if (bytes_left == 0) in_chunk = 1'b0;
      deframed_q.push_back(r);
      return;
    end
    case (hdr_pos)
      HB_CHK_LO: begin
        hdr = '0;
        hdr.chk[7:0] = b;
      end
      HB_CHK_HI:  hdr.chk[15:8] = b;
      HB_TYPE:    hdr.msg_type = b;
      HB_TOTAL:   hdr.total = b;
      HB_CUR:     hdr.cur = b;
      HB_SIZE_LO: hdr.size_lo = b;
      default: ;
    endcase
    if (hdr_pos != HB_SIZE_HI) begin
      hdr_pos = hdr_pos + 1'b1;
      return;
    end
    hdr_pos = HB_CHK_LO;
    size = {b, hdr.size_lo};
    r.msg_type = hdr.msg_type;
    if (hdr.chk != check_word_m || size > max_chunk_m || hdr.cur > hdr.total) begin
      r.status = ST_REJECT;
      deframed_q.push_back(r);
      return;
    end
    held_type   = hdr.msg_type;
    chunk_final = (hdr.cur == hdr.total);
    if (size == 0) begin
      if (chunk_final) begin
        r.status = ST_EMPTY_END;
        r.eom    = 1'b1;
        deframed_q.push_back(r);
      end
      return;
    end
    bytes_left = size;
    in_chunk   = 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int chunk_size();
    int r;
    int size;
    r = $urandom_range(0, 99);
    if (r < 8 && max_chunk_m < 40) return max_chunk_m;
    if (r < 22) size = 0;
    else if (r < 85) size = $urandom_range(1, 10);
    else if (r < 97) size = $urandom_range(11, 40);
    else size = $urandom_range(100, 250);
    if (size > max_chunk_m) size = $urandom_range(0, max_chunk_m);
    return size;
  endfunction

  task automatic add_header(logic [15:0] chk, logic [7:0] mtype, logic [7:0] total,
                            logic [7:0] cur, logic [15:0] size);
    rx_stream_q.push_back(chk[7:0]);
    rx_stream_q.push_back(chk[15:8]);
    rx_stream_q.push_back(8'($urandom_range(0, 255)));
    rx_stream_q.push_back(mtype);
    rx_stream_q.push_back(total);
    rx_stream_q.push_back(cur);
    rx_stream_q.push_back(size[7:0]);
    rx_stream_q.push_back(size[15:8]);
  endtask

  task automatic add_chunk(logic [15:0] chk, logic [7:0] mtype, logic [7:0] total,
                           logic [7:0] cur, int size);
    add_header(chk, mtype, total, cur, 16'(size));
    repeat (size) rx_stream_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic gen_phase(int target);
    int         start;
    int         kind;
    int         total;
    int         n;
    logic [7:0] mtype;
    logic [7:0] cur;
    start = rx_stream_q.size();
    while (rx_stream_q.size() - start < target) begin
      kind  = $urandom_range(0, 99);
      mtype = $urandom_range(0, 255);
      if (kind < 72) begin
        total = $urandom_range(0, 3);
        for (int c = 0; c <= total; c++) add_chunk(check_word_m, mtype, total, c, chunk_size());
      end else if (kind < 80 || (kind < 93 && max_chunk_m == 16'hFFFF)) begin
        add_header(check_word_m ^ (16'd1 << $urandom_range(0, 15)), mtype,
                   $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 65535));
      end else if (kind < 87) begin
        total = $urandom_range(0, 254);
        cur   = $urandom_range(total + 1, 255);
        add_header(check_word_m, mtype, total, cur, $urandom_range(0, max_chunk_m));
      end else if (kind < 93) begin
        total = $urandom_range(0, 255);
        add_header(check_word_m, mtype, total, $urandom_range(0, total),
                   $urandom_range(max_chunk_m + 1, 65535));
      end else begin
        // keep header alignment: noise length is a multiple of the header length
        n = $urandom_range(1, 20);
        n = n + (8 - n % 8) % 8;
        repeat (n) rx_stream_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic wait_idle();
    while (!(rx_stream_q.size() == 0 && !in_tvalid && deframed_q.size() == 0))
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_regs(logic [WORD_W-1:0] chk, logic [WORD_W-1:0] max_bytes);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CHECK_WORD;
    cfg_data  <= chk;
    @(posedge clk);
    cfg_index <= REG_MAX_CHUNK;
    cfg_data  <= max_bytes;
    @(posedge clk);
    cfg_we <= 1'b0;
    check_word_m = chk;
    max_chunk_m  = max_bytes;
    @(negedge clk);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $realtime, name, want, got);
      mismatch_count++;
    end
  endtask

  initial begin
    forever #1 clk = ~clk;
  end

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap  <= 0;
    end else if (in_tvalid && !in_tready) begin
      // hold the offered byte
    end else if (send_gap != 0) begin
      in_tvalid <= 1'b0;
      send_gap  <= send_gap - 1;
    end else if (rx_stream_q.size() != 0) begin
      in_tvalid <= 1'b1;
      in_tdata  <= rx_stream_q.pop_front();
      send_gap  <= pick_gap();
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready   <= 1'b0;
      ready_gap    <= 0;
      stall_left   <= 0;
      stall_served <= 0;
    end else if (stall_served != stall_requests) begin
      stall_served <= stall_requests;
      stall_left   <= LONG_STALL;
      out_tready   <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (ready_gap != 0) begin
      ready_gap  <= ready_gap - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      ready_gap  <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) deframe_byte(in_tdata);
  end

  always @(posedge clk) begin
    deframed_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (deframed_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual data 0x%0h last %0b user %0d",
                 $realtime, out_tdata, out_tlast, out_tuser);
        mismatch_count++;
      end else begin
        want = deframed_q.pop_front();
        check_field("payload_byte", want.payload, out_tdata[7:0]);
        check_field("message_type", want.msg_type, out_tdata[15:8]);
        check_field("end_of_message", want.eom, out_tlast);
        check_field("status", want.status, out_tuser);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (rx_stream_q.size() == 0 && !in_tvalid && deframed_q.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_chunked_message_deframer: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: rejected header, empty non-final chunk, empty final chunk
    add_header(~CHECK_WORD_RST, 8'h00, 8'h00, 8'hFF, 16'hFFFF);
    add_header(CHECK_WORD_RST, 8'h5A, 8'hFF, 8'h00, 16'h0000);
    add_header(CHECK_WORD_RST, 8'hFF, 8'hFF, 8'hFF, 16'h0000);
    wait_idle();
    gen_phase(PHASE_BYTES);
    wait_idle();

    write_regs(16'hFFFF, 16'h0000);
    idle_on = 1'b0;
    gen_phase(PHASE_BYTES);
    wait_idle();
    idle_on = 1'b1;

    write_regs(16'h0000, 16'd16);
    gen_phase(PHASE_BYTES);
    wait_idle();

    write_regs(16'hA55A, 16'hFFFF);
    gen_phase(PHASE_BYTES);
    stall_requests = stall_requests + 1;
    wait_idle();

    write_regs(16'h1234, 16'd7);
    gen_phase(PHASE_BYTES);
    wait_idle();

    write_regs(CHECK_WORD_RST, 16'hFFFE);
    gen_phase(PHASE_BYTES);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("tb_chunked_message_deframer: done, clean");
    end else begin
      $display("tb_chunked_message_deframer: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/cmd_pkg.sv
sv/cmd_hdr_chk.sv
sv/chunked_message_deframer.sv
sv/cmd_checker.sv
tb/sv/tb_chunked_message_deframer.sv
